### src/rtsb_pkg.sv
// ----------------------------------------------------------------------------
// rtsb_pkg: shared types and constants of the tile-scan block address unit
// Field widths, tile limits, configuration register codes and the payload
// structs of the input and result channels.
// ----------------------------------------------------------------------------
package rtsb_pkg;

  localparam int MAX_TILES_PER_DIM  = 4;
  localparam int BLOCKS_PER_SB_SIDE = 2;
  localparam int SB_PIXELS          = 64;

  localparam int COORD_W  = 11;
  localparam int ADDR_W   = 20;
  localparam int OFFS_W   = 22;
  localparam int FRAME_W  = 16;
  localparam int CNT_W    = 3;
  localparam int FIELD_W  = 16;
  localparam int PACK_FIELDS = 4;
  localparam int PACK_W   = FIELD_W * PACK_FIELDS;
  localparam int PIDX_W   = $clog2(PACK_FIELDS);

  localparam int SIZE_W   = FIELD_W + 1;
  localparam int BND_W    = SIZE_W + $clog2(MAX_TILES_PER_DIM + 1);
  localparam int TIDX_W   = (MAX_TILES_PER_DIM > 1) ? $clog2(MAX_TILES_PER_DIM) : 1;
  localparam int SB_COORD_W = $clog2((2 ** COORD_W - 1) / BLOCKS_PER_SB_SIDE + 1);
  localparam int SBW_W    = $clog2((2 ** FRAME_W - 1) / SB_PIXELS + 2);
  localparam int SB_BLOCKS = BLOCKS_PER_SB_SIDE * BLOCKS_PER_SB_SIDE;
  localparam int POS_W    = (SB_BLOCKS > 1) ? $clog2(SB_BLOCKS) : 1;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_TILE_COLS    = 3'd1,
    REG_TILE_ROWS    = 3'd2,
    REG_TILE_WIDTHS  = 3'd3,
    REG_TILE_HEIGHTS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] block_col;
    logic [COORD_W-1:0] block_row;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] sb_tile_addr;
    logic [OFFS_W-1:0] block_offset;
  } out_t;

  // Zero means one tile, anything above the limit means the limit.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) r = CNT_W'(1);
    else if (c > CNT_W'(MAX_TILES_PER_DIM)) r = CNT_W'(MAX_TILES_PER_DIM);
    return r;
  endfunction

  // Tile size in superblocks: the stored field plus one.
  function automatic logic [SIZE_W-1:0] field_size(input logic [PACK_W-1:0] packed_f,
                                                   input logic [PIDX_W-1:0] i);
    logic [FIELD_W-1:0] f;
    f = packed_f[FIELD_W*i +: FIELD_W];
    return SIZE_W'(f) + SIZE_W'(1);
  endfunction

endpackage

### src/raster_to_tile_scan_block_address_unit.sv
// ----------------------------------------------------------------------------
// raster_to_tile_scan_block_address_unit: 32x32 block to tile-scan address
// Looks up the tile of a block's superblock from registered tile boundaries,
// forms the superblock's tile-scan address and the block's buffer offset.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-----------------------
//  input    | start, busy, in_data                    | start && !busy
//  result   | out_valid, out_data                     | out_valid, one cycle
//  config   | psel, penable, pwrite, paddr, pwdata,   | psel && penable &&
//           | prdata, pready                          | pwrite && pready
//
//  One item per clock while busy is low; each result passes through the
//  registered steps input capture, tile lookup, three multipliers and final
//  sum before it reaches the result ports.
//  busy is high during reset and for the first cycle after it, while the tile
//  boundary registers load; it is low afterwards, since the result side never
//  stalls.
//  Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module raster_to_tile_scan_block_address_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  rtsb_pkg::in_t                      in_data,
  output logic                               out_valid,
  output rtsb_pkg::out_t                     out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rtsb_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rtsb_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rtsb_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int NT = rtsb_pkg::MAX_TILES_PER_DIM;

  // configuration registers
  logic [rtsb_pkg::FRAME_W-1:0] frame_w_r;
  logic [rtsb_pkg::CNT_W-1:0]   col_cnt_r;
  logic [rtsb_pkg::CNT_W-1:0]   row_cnt_r;
  logic [rtsb_pkg::PACK_W-1:0]  widths_r;
  logic [rtsb_pkg::PACK_W-1:0]  heights_r;

  logic                         cfg_wr;
  rtsb_pkg::reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = rtsb_pkg::reg_idx_t'(paddr[rtsb_pkg::CFG_ADDR_W-1 -: rtsb_pkg::CFG_IDX_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= '0;
      col_cnt_r <= rtsb_pkg::CNT_W'(1);
      row_cnt_r <= rtsb_pkg::CNT_W'(1);
      widths_r  <= '0;
      heights_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rtsb_pkg::REG_FRAME_WIDTH:  frame_w_r <= pwdata[rtsb_pkg::FRAME_W-1:0];
        rtsb_pkg::REG_TILE_COLS:    col_cnt_r <= pwdata[rtsb_pkg::CNT_W-1:0];
        rtsb_pkg::REG_TILE_ROWS:    row_cnt_r <= pwdata[rtsb_pkg::CNT_W-1:0];
        rtsb_pkg::REG_TILE_WIDTHS:  widths_r  <= pwdata[rtsb_pkg::PACK_W-1:0];
        rtsb_pkg::REG_TILE_HEIGHTS: heights_r <= pwdata[rtsb_pkg::PACK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rtsb_pkg::REG_FRAME_WIDTH:  prdata = rtsb_pkg::CFG_DATA_W'(frame_w_r);
      rtsb_pkg::REG_TILE_COLS:    prdata = rtsb_pkg::CFG_DATA_W'(col_cnt_r);
      rtsb_pkg::REG_TILE_ROWS:    prdata = rtsb_pkg::CFG_DATA_W'(row_cnt_r);
      rtsb_pkg::REG_TILE_WIDTHS:  prdata = rtsb_pkg::CFG_DATA_W'(widths_r);
      rtsb_pkg::REG_TILE_HEIGHTS: prdata = rtsb_pkg::CFG_DATA_W'(heights_r);
      default:                    prdata = '0;
    endcase
  end

  // tile boundaries, refreshed every cycle from the configuration
  logic [rtsb_pkg::BND_W-1:0] col_bnd_r   [NT];
  logic [rtsb_pkg::BND_W-1:0] col_bnd_nxt [NT];
  logic [rtsb_pkg::BND_W-1:0] row_bnd_r   [NT];
  logic [rtsb_pkg::BND_W-1:0] row_bnd_nxt [NT];
  logic [rtsb_pkg::CNT_W-1:0] col_use_r;
  logic [rtsb_pkg::CNT_W-1:0] row_use_r;

  always_comb begin
    logic [rtsb_pkg::BND_W-1:0] cacc;
    logic [rtsb_pkg::BND_W-1:0] racc;
    cacc = '0;
    racc = '0;
    for (int i = 0; i < NT; i++) begin
      col_bnd_nxt[i] = cacc;
      row_bnd_nxt[i] = racc;
      cacc = cacc + rtsb_pkg::BND_W'(rtsb_pkg::field_size(widths_r, rtsb_pkg::PIDX_W'(i)));
      racc = racc + rtsb_pkg::BND_W'(rtsb_pkg::field_size(heights_r, rtsb_pkg::PIDX_W'(i)));
    end
  end

  always_ff @(posedge clk) begin
    col_bnd_r <= col_bnd_nxt;
    row_bnd_r <= row_bnd_nxt;
    col_use_r <= rtsb_pkg::clamp_count(col_cnt_r);
    row_use_r <= rtsb_pkg::clamp_count(row_cnt_r);
  end

  // hold busy for one cycle after reset so the boundaries settle
  logic busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else        busy_r <= 1'b0;
  end
  assign busy = busy_r;

  logic accept;
  assign accept = start && !busy_r;

  // stage 1: input capture
  logic                            s1_vld_r;
  logic [rtsb_pkg::SB_COORD_W-1:0] s1_sbx_r;
  logic [rtsb_pkg::SB_COORD_W-1:0] s1_sby_r;
  logic [rtsb_pkg::POS_W-1:0]      s1_pos_r;

  // stage 2: tile lookup
  logic                            s2_vld_r;
  logic [rtsb_pkg::SB_COORD_W-1:0] s2_dx_r;
  logic [rtsb_pkg::SB_COORD_W-1:0] s2_dy_r;
  logic [rtsb_pkg::SB_COORD_W-1:0] s2_cstart_r;
  logic [rtsb_pkg::SB_COORD_W-1:0] s2_rstart_r;
  logic [rtsb_pkg::SIZE_W-1:0]     s2_tw_r;
  logic [rtsb_pkg::SIZE_W-1:0]     s2_th_r;
  logic [rtsb_pkg::POS_W-1:0]      s2_pos_r;

  // stage 3: products
  logic                            s3_vld_r;
  logic [rtsb_pkg::OFFS_W-1:0]     s3_prow_r;
  logic [rtsb_pkg::OFFS_W-1:0]     s3_pcol_r;
  logic [rtsb_pkg::OFFS_W-1:0]     s3_pin_r;
  logic [rtsb_pkg::SB_COORD_W-1:0] s3_dx_r;
  logic [rtsb_pkg::POS_W-1:0]      s3_pos_r;

  logic                            out_valid_r;
  rtsb_pkg::out_t                  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= accept;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      out_valid_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sbx_r <= rtsb_pkg::SB_COORD_W'(in_data.block_col / rtsb_pkg::BLOCKS_PER_SB_SIDE);
      s1_sby_r <= rtsb_pkg::SB_COORD_W'(in_data.block_row / rtsb_pkg::BLOCKS_PER_SB_SIDE);
      s1_pos_r <= rtsb_pkg::POS_W'(
                    (in_data.block_row % rtsb_pkg::BLOCKS_PER_SB_SIDE)
                    * rtsb_pkg::BLOCKS_PER_SB_SIDE
                    + in_data.block_col % rtsb_pkg::BLOCKS_PER_SB_SIDE);
    end
  end

  // pick the last tile in use whose start is not past the coordinate
  logic [rtsb_pkg::TIDX_W-1:0]     tx;
  logic [rtsb_pkg::TIDX_W-1:0]     ty;
  logic [rtsb_pkg::SB_COORD_W-1:0] cstart;
  logic [rtsb_pkg::SB_COORD_W-1:0] rstart;

  always_comb begin
    tx = '0;
    ty = '0;
    for (int i = 0; i < NT; i++) begin
      if (rtsb_pkg::CNT_W'(i) < col_use_r &&
          rtsb_pkg::BND_W'(s1_sbx_r) >= col_bnd_r[i]) tx = rtsb_pkg::TIDX_W'(i);
      if (rtsb_pkg::CNT_W'(i) < row_use_r &&
          rtsb_pkg::BND_W'(s1_sby_r) >= row_bnd_r[i]) ty = rtsb_pkg::TIDX_W'(i);
    end
    // a selected start never exceeds its coordinate, so it fits the coordinate width
    cstart = col_bnd_r[tx][rtsb_pkg::SB_COORD_W-1:0];
    rstart = row_bnd_r[ty][rtsb_pkg::SB_COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    s2_dx_r     <= s1_sbx_r - cstart;
    s2_dy_r     <= s1_sby_r - rstart;
    s2_cstart_r <= cstart;
    s2_rstart_r <= rstart;
    s2_tw_r     <= rtsb_pkg::field_size(widths_r, rtsb_pkg::PIDX_W'(tx));
    s2_th_r     <= rtsb_pkg::field_size(heights_r, rtsb_pkg::PIDX_W'(ty));
    s2_pos_r    <= s1_pos_r;
  end

  logic [rtsb_pkg::SBW_W-1:0] sb_per_row;
  assign sb_per_row = rtsb_pkg::SBW_W'(frame_w_r / rtsb_pkg::SB_PIXELS) + rtsb_pkg::SBW_W'(1);

  always_ff @(posedge clk) begin
    s3_prow_r <= rtsb_pkg::OFFS_W'(sb_per_row) * rtsb_pkg::OFFS_W'(s2_rstart_r);
    s3_pcol_r <= rtsb_pkg::OFFS_W'(s2_th_r) * rtsb_pkg::OFFS_W'(s2_cstart_r);
    s3_pin_r  <= rtsb_pkg::OFFS_W'(s2_dy_r) * rtsb_pkg::OFFS_W'(s2_tw_r);
    s3_dx_r   <= s2_dx_r;
    s3_pos_r  <= s2_pos_r;
  end

  // all arithmetic wraps at the offset width; the address takes its low bits
  logic [rtsb_pkg::OFFS_W-1:0] addr_full;
  logic [rtsb_pkg::OFFS_W-1:0] offs_full;

  always_comb begin
    addr_full = s3_prow_r + s3_pcol_r + s3_pin_r + rtsb_pkg::OFFS_W'(s3_dx_r);
    offs_full = addr_full * rtsb_pkg::OFFS_W'(rtsb_pkg::SB_BLOCKS)
                + rtsb_pkg::OFFS_W'(s3_pos_r);
  end

  always_ff @(posedge clk) begin
    out_data_r.sb_tile_addr <= addr_full[rtsb_pkg::ADDR_W-1:0];
    out_data_r.block_offset <= offs_full;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/rtsb_checker.sv
// ----------------------------------------------------------------------------
// rtsb_checker: port-level checks of the tile-scan block address unit
// Latency, busy behavior and the tie between superblock address and
// block offset, watched on the top-level ports only.
// ----------------------------------------------------------------------------
module rtsb_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input rtsb_pkg::in_t  in_data,
  input logic           out_valid,
  input rtsb_pkg::out_t out_data
);

  localparam int POS_BITS = $clog2(rtsb_pkg::SB_BLOCKS);

  // every accepted item gives its result once it has passed the pipeline
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted item produced no result");

  // no result without an accepted item behind it in the pipeline
  a_latency_rev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without matching item");

  // busy drops once reset is released
  a_busy_low: assert property (@(posedge clk)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset");

  // the block offset carries the superblock address above the in-superblock position
  a_offs_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.block_offset[POS_BITS +: rtsb_pkg::ADDR_W]
                   == out_data.sb_tile_addr))
    else $error("block offset does not match superblock address");

endmodule

bind raster_to_tile_scan_block_address_unit rtsb_checker u_rtsb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

### tb/raster_to_tile_scan_block_address_unit_tb.sv
// ----------------------------------------------------------------------------
// raster_to_tile_scan_block_address_unit_tb: block address unit testbench
// Feeds block coordinates through the command port under several tile
// layouts written over the register port. Each taken item is turned into an
// expected superblock address and block offset, which are matched in order
// against the result strobes.
// ----------------------------------------------------------------------------
module raster_to_tile_scan_block_address_unit_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  rtsb_pkg::in_t                   in_data = '0;
  logic                            out_valid;
  rtsb_pkg::out_t                  out_data;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [rtsb_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [rtsb_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [rtsb_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  // register contents as last written
  logic [rtsb_pkg::FRAME_W-1:0] frame_w_m1;
  logic [rtsb_pkg::CNT_W-1:0]   col_cnt_m;
  logic [rtsb_pkg::CNT_W-1:0]   row_cnt_m;
  logic [rtsb_pkg::PACK_W-1:0]  tile_widths;
  logic [rtsb_pkg::PACK_W-1:0]  tile_heights;

  rtsb_pkg::in_t   coord_queue[$];
  rtsb_pkg::out_t  addr_queue[$];
  int    gap_left = 0;
  bit    idle_on = 1'b1;
  int    mismatches = 0;
  int    cycle_cnt = 0;

  raster_to_tile_scan_block_address_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic int tiles_in_use(logic [rtsb_pkg::CNT_W-1:0] c);
    if (c == '0) return 1;
    if (c > rtsb_pkg::MAX_TILES_PER_DIM) return rtsb_pkg::MAX_TILES_PER_DIM;
    return int'(c);
  endfunction

  function automatic longint unsigned tile_size(logic [rtsb_pkg::PACK_W-1:0] sizes, int i);
    return longint'(sizes[rtsb_pkg::FIELD_W*i +: rtsb_pkg::FIELD_W]) + 1;
  endfunction

  // last tile whose start is not past the coordinate
  function automatic void find_tile(input longint unsigned coord,
                                    input logic [rtsb_pkg::PACK_W-1:0] sizes,
                                    input int count, output int idx,
                                    output longint unsigned first);
    longint unsigned bound;
    bound = 0;
    idx = 0;
    first = 0;
    for (int i = 0; i < count; i++) begin
      if (coord >= bound) begin
        idx = i;
        first = bound;
      end
      bound += tile_size(sizes, i);
    end
  endfunction

  function automatic rtsb_pkg::out_t tile_scan_address(rtsb_pkg::in_t blk);
    longint unsigned sbx, sby, sbw, col_first, row_first, tw, th, addr, offs;
    int tx, ty;
    rtsb_pkg::out_t r;
    sbx = longint'(blk.block_col) / rtsb_pkg::BLOCKS_PER_SB_SIDE;
    sby = longint'(blk.block_row) / rtsb_pkg::BLOCKS_PER_SB_SIDE;
    sbw = (longint'(frame_w_m1) + rtsb_pkg::SB_PIXELS) / rtsb_pkg::SB_PIXELS;
    find_tile(sbx, tile_widths, tiles_in_use(col_cnt_m), tx, col_first);
    find_tile(sby, tile_heights, tiles_in_use(row_cnt_m), ty, row_first);
    tw = tile_size(tile_widths, tx);
    th = tile_size(tile_heights, ty);
    addr = sbw * row_first + th * col_first + (sby - row_first) * tw + (sbx - col_first);
    offs = addr * rtsb_pkg::SB_BLOCKS
         + (longint'(blk.block_row) % rtsb_pkg::BLOCKS_PER_SB_SIDE)
           * rtsb_pkg::BLOCKS_PER_SB_SIDE
         + longint'(blk.block_col) % rtsb_pkg::BLOCKS_PER_SB_SIDE;
    r.sb_tile_addr = addr[rtsb_pkg::ADDR_W-1:0];
    r.block_offset = offs[rtsb_pkg::OFFS_W-1:0];
    return r;
  endfunction

  // coordinate within a block or two of a tile boundary
  function automatic logic [rtsb_pkg::COORD_W-1:0] near_boundary(
      logic [rtsb_pkg::PACK_W-1:0] sizes);
    longint unsigned bound;
    longint signed c;
    int n;
    n = $urandom_range(0, rtsb_pkg::MAX_TILES_PER_DIM - 1);
    bound = 0;
    for (int i = 0; i < n; i++) bound += tile_size(sizes, i);
    c = longint'(bound) * rtsb_pkg::BLOCKS_PER_SB_SIDE + $urandom_range(0, 3) - 2;
    if (c < 0) c = 0;
    if (c > 2 ** rtsb_pkg::COORD_W - 1)
      c = $urandom_range(2 ** rtsb_pkg::COORD_W - 4, 2 ** rtsb_pkg::COORD_W - 1);
    return c[rtsb_pkg::COORD_W-1:0];
  endfunction

  function automatic rtsb_pkg::in_t random_coord();
    rtsb_pkg::in_t b;
    b.block_col = ($urandom_range(0, 3) == 0) ? near_boundary(tile_widths)
                                              : rtsb_pkg::COORD_W'($urandom_range(0, 2047));
    b.block_row = ($urandom_range(0, 3) == 0) ? near_boundary(tile_heights)
                                              : rtsb_pkg::COORD_W'($urandom_range(0, 2047));
    return b;
  endfunction

  function automatic logic [rtsb_pkg::PACK_W-1:0] random_sizes();
    logic [rtsb_pkg::PACK_W-1:0] p;
    for (int i = 0; i < rtsb_pkg::PACK_FIELDS; i++) begin
      case ($urandom_range(0, 5))
        0:       p[rtsb_pkg::FIELD_W*i +: rtsb_pkg::FIELD_W] = '0;
        1:       p[rtsb_pkg::FIELD_W*i +: rtsb_pkg::FIELD_W] = '1;
        2:       p[rtsb_pkg::FIELD_W*i +: rtsb_pkg::FIELD_W] =
                   rtsb_pkg::FIELD_W'($urandom);
        default: p[rtsb_pkg::FIELD_W*i +: rtsb_pkg::FIELD_W] =
                   rtsb_pkg::FIELD_W'($urandom_range(0, 300));
      endcase
    end
    return p;
  endfunction

  task automatic write_reg(input rtsb_pkg::reg_idx_t idx,
                           input logic [rtsb_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= rtsb_pkg::CFG_ADDR_W'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rtsb_pkg::REG_FRAME_WIDTH:  frame_w_m1 = val[rtsb_pkg::FRAME_W-1:0];
      rtsb_pkg::REG_TILE_COLS:    col_cnt_m = val[rtsb_pkg::CNT_W-1:0];
      rtsb_pkg::REG_TILE_ROWS:    row_cnt_m = val[rtsb_pkg::CNT_W-1:0];
      rtsb_pkg::REG_TILE_WIDTHS:  tile_widths = val;
      rtsb_pkg::REG_TILE_HEIGHTS: tile_heights = val;
      default: ;
    endcase
  endtask

  task automatic write_layout(input logic [rtsb_pkg::CFG_DATA_W-1:0] fw,
                              input logic [rtsb_pkg::CFG_DATA_W-1:0] cols,
                              input logic [rtsb_pkg::CFG_DATA_W-1:0] rows,
                              input logic [rtsb_pkg::PACK_W-1:0] widths,
                              input logic [rtsb_pkg::PACK_W-1:0] heights);
    write_reg(rtsb_pkg::REG_FRAME_WIDTH, fw);
    write_reg(rtsb_pkg::REG_TILE_COLS, cols);
    write_reg(rtsb_pkg::REG_TILE_ROWS, rows);
    write_reg(rtsb_pkg::REG_TILE_WIDTHS, widths);
    write_reg(rtsb_pkg::REG_TILE_HEIGHTS, heights);
  endtask

  // queue items, then hold until every result is back and the pipe is empty
  task automatic run_phase(input int n_random, input bit with_directed, input bit idle);
    rtsb_pkg::in_t corners[$];
    corners = '{'{11'd0, 11'd0}, '{11'd2047, 11'd2047}, '{11'd2047, 11'd0},
                '{11'd0, 11'd2047}, '{11'd1, 11'd0}, '{11'd0, 11'd1}, '{11'd1, 11'd1},
                '{11'd1024, 11'd1024}, '{11'd1023, 11'd1023},
                '{11'h555, 11'h2aa}, '{11'h2aa, 11'h555}};
    idle_on = idle;
    if (with_directed) foreach (corners[i]) coord_queue.push_back(corners[i]);
    for (int i = 0; i < n_random; i++) coord_queue.push_back(random_coord());
    while (coord_queue.size() != 0 || start || addr_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
  endtask

  // driver: present the head of the queue, pop it once taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        addr_queue.push_back(tile_scan_address(in_data));
        void'(coord_queue.pop_front());
        if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 4);
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (coord_queue.size() != 0) begin
        start <= 1'b1;
        in_data <= coord_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (addr_queue.size() == 0) begin
        report_mismatch("unexpected result, sb_tile_addr", out_data.sb_tile_addr, 0);
      end else begin
        rtsb_pkg::out_t want;
        want = addr_queue.pop_front();
        if (out_data.sb_tile_addr !== want.sb_tile_addr)
          report_mismatch("sb_tile_addr", out_data.sb_tile_addr, want.sb_tile_addr);
        if (out_data.block_offset !== want.block_offset)
          report_mismatch("block_offset", out_data.block_offset, want.block_offset);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    frame_w_m1 = '0;
    col_cnt_m = rtsb_pkg::CNT_W'(1);
    row_cnt_m = rtsb_pkg::CNT_W'(1);
    tile_widths = '0;
    tile_heights = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset layout: one 1x1 tile, frame one superblock wide
    run_phase(100, 1'b1, 1'b1);
    // largest frame and tiles
    write_layout(64'hffff, 64'd4, 64'd4, '1, '1);
    run_phase(100, 1'b1, 1'b1);
    // zero counts act as one tile
    write_layout(64'd0, 64'd0, 64'd0, '0, '0);
    run_phase(100, 1'b0, 1'b1);
    // counts above the limit saturate; small tiles put boundaries in range
    write_layout(64'd1919, 64'd7, 64'd5, {16'd255, 16'd99, 16'd0, 16'd3},
                 {16'd40, 16'd1, 16'd17, 16'd7});
    run_phase(120, 1'b0, 1'b1);
    // tall tiles push the address past its field width
    write_layout(64'hffff, 64'd4, 64'd4, {4{16'h00ff}}, {4{16'hffff}});
    run_phase(100, 1'b0, 1'b1);
    for (int p = 0; p < 5; p++) begin
      write_layout(64'($urandom_range(0, 65535)), 64'($urandom_range(0, 7)),
                   64'($urandom_range(0, 7)), random_sizes(), random_sizes());
      run_phase(120, 1'b0, p < 4);
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/rtsb_pkg.sv
src/raster_to_tile_scan_block_address_unit.sv
src/rtsb_checker.sv
tb/raster_to_tile_scan_block_address_unit_tb.sv
